// ----- rtl/core/stb_pkg.sv -----
// shared types and constants for the soft timer bank
package stb_pkg;

  localparam int SLOT_FW = 3;
  localparam int TIME_W  = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_UNSET = 2'd2,
    FUNC_SCAN  = 2'd3
  } func_t;

  typedef struct packed {
    logic              repeats;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] start;
  } slot_rec_t;

  typedef struct packed {
    logic acc;
    logic rd_en;
    logic ev_vld;
    logic flush;
  } stb_cmd_t;

endpackage

// ----- rtl/core/stb_ram.sv -----
// generic single write, single read ram with registered read data
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/stb_ctrl.sv -----
// controller state machine: accepts items and sequences the slot scan
module stb_ctrl
  import stb_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  output logic              busy,
  output stb_cmd_t          cmd,
  output logic [SLOT_W-1:0] rd_addr,
  output logic [SLOT_W-1:0] ev_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_t            state_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [SLOT_W-1:0] ev_idx_r;
  logic              ev_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ev_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start && func_t'(in_func) == FUNC_SCAN) begin
            state_r  <= ST_SCAN;
            rd_idx_r <= '0;
          end
        end
        ST_SCAN: begin
          ev_vld_r <= 1'b1;
          ev_idx_r <= rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          ev_vld_r <= 1'b0;
          state_r  <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.acc    = start && !busy;
  assign cmd.rd_en  = (state_r == ST_SCAN);
  assign cmd.ev_vld = ev_vld_r;
  assign cmd.flush  = (state_r == ST_FLUSH);
  assign rd_addr    = rd_idx_r;
  assign ev_idx     = ev_idx_r;

  a_idle_no_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FLUSH) |-> !ev_vld_r)
    else $error("slot evaluation outside scan");

  a_scan_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= LAST_IDX))
    else $error("scan index past last slot");

  a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> ($past(state_r) == ST_SCAN && ev_idx_r == $past(rd_idx_r)))
    else $error("evaluated slot does not match read slot");

endmodule

// ----- rtl/core/stb_dp.sv -----
// datapath: tick counter, armed flags, slot ram, expiry check and result register
module stb_dp
  import stb_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W    = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stb_cmd_t           cmd,
  input  logic [SLOT_W-1:0]  rd_addr,
  input  logic [SLOT_W-1:0]  ev_idx,
  input  logic [1:0]         in_func,
  input  logic [SLOT_FW-1:0] in_slot,
  input  logic [TIME_W-1:0]  in_duration_ms,
  input  logic               in_periodic,
  output logic               out_strobe,
  output logic               out_fired,
  output logic [SLOT_FW-1:0] out_fired_slot,
  output logic               out_last,
  output logic [TIME_W-1:0]  out_tick_count
);

  localparam int REC_W = $bits(slot_rec_t);

  logic [TIME_W-1:0]    tick_r, tick_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_fired_r, out_fired_nxt;
  logic [SLOT_FW-1:0]   out_slot_r, out_slot_nxt;
  logic                 out_last_r, out_last_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_rec_t         ram_wdata;
  slot_rec_t         rec;
  logic [REC_W-1:0]  ram_rdata;
  logic [TIME_W-1:0] elapsed;
  logic              slot_ok;
  logic              hit;

  stb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (REC_W'(ram_wdata)),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rec     = slot_rec_t'(ram_rdata);
  assign elapsed = tick_r - rec.start;
  assign slot_ok = (32'(in_slot) < 32'(NUM_SLOTS));
  assign hit     = cmd.ev_vld && armed_r[ev_idx] && (elapsed >= rec.duration);

  always_comb begin
    tick_nxt       = tick_r;
    armed_nxt      = armed_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    out_strobe_nxt = 1'b0;
    out_fired_nxt  = 1'b0;
    out_slot_nxt   = '0;
    out_last_nxt   = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = SLOT_W'(in_slot);
    ram_wdata      = '{repeats: in_periodic, duration: in_duration_ms, start: tick_r};

    if (cmd.acc) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
      unique case (func_t'(in_func))
        FUNC_TICK: tick_nxt = tick_r + 1'b1;
        FUNC_SET: begin
          if (slot_ok) begin
            armed_nxt[SLOT_W'(in_slot)] = 1'b1;
            ram_we = 1'b1;
          end
        end
        FUNC_UNSET: begin
          if (slot_ok) begin
            armed_nxt[SLOT_W'(in_slot)] = 1'b0;
          end
        end
        FUNC_SCAN: begin
          out_strobe_nxt = 1'b0;
          out_last_nxt   = 1'b0;
        end
      endcase
    end

    // a fire is held back until the next one shows whether it is the final item
    if (hit) begin
      if (pend_vld_r) begin
        out_strobe_nxt = 1'b1;
        out_fired_nxt  = 1'b1;
        out_slot_nxt   = SLOT_FW'(pend_idx_r);
      end
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = ev_idx;
      if (rec.repeats) begin
        ram_we    = 1'b1;
        ram_waddr = ev_idx;
        ram_wdata = '{repeats: 1'b1, duration: rec.duration, start: tick_r};
      end else begin
        armed_nxt[ev_idx] = 1'b0;
      end
    end

    if (cmd.flush) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
      out_fired_nxt  = pend_vld_r;
      out_slot_nxt   = pend_vld_r ? SLOT_FW'(pend_idx_r) : '0;
      pend_vld_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      armed_r      <= '0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      tick_r       <= tick_nxt;
      armed_r      <= armed_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    pend_idx_r  <= pend_idx_nxt;
    out_fired_r <= out_fired_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_last       = out_last_r;
  assign out_tick_count = tick_r;

  a_non_last_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_last_r) |-> out_fired_r)
    else $error("intermediate item without a fire");

endmodule

// ----- rtl/core/soft_timer_bank_unit.sv -----
// top level of the soft timer bank: controller, datapath and slot ram
// Tick, set and unset are accepted while idle and their single result is strobed on the
// next cycle; busy stays low for them. A scan raises busy through its scan, drain and
// flush states: the slot ram gives one slot record per cycle through its read port, the
// expiry check runs in the cycle after each read, and each expired slot produces one
// result as the scan walks the slots. The final result of a scan is strobed in the first
// cycle after busy falls. The receiver cannot stall: every strobed result must be taken
// in that cycle. Only slots 0 to NUM_SLOTS - 1, and never above 7, are addressable.
module soft_timer_bank_unit
  import stb_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [SLOT_FW-1:0] in_slot,
  input  logic [TIME_W-1:0]  in_duration_ms,
  input  logic               in_periodic,
  output logic               out_strobe,
  output logic               out_fired,
  output logic [SLOT_FW-1:0] out_fired_slot,
  output logic               out_last,
  output logic [TIME_W-1:0]  out_tick_count
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  stb_cmd_t          cmd;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] ev_idx;

  stb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .ev_idx  (ev_idx)
  );

  stb_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .ev_idx         (ev_idx),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_duration_ms (in_duration_ms),
    .in_periodic    (in_periodic),
    .out_strobe     (out_strobe),
    .out_fired      (out_fired),
    .out_fired_slot (out_fired_slot),
    .out_last       (out_last),
    .out_tick_count (out_tick_count)
  );

endmodule
